>>> rtl/hps_pkg.sv
// Package for the heading proportional steering block.
// Payload and command types, fixed-point widths, reset values and the CORDIC angle table.
// No dependencies.
package hps_pkg;

   localparam int CORDIC_ITERATIONS_DEFAULT = 16;
   localparam int ANG_TABLE_LEN             = 24;
   localparam int TABLE_IDX_W               = 5;
   localparam int ATAN_W                    = 20;
   localparam int CSR_INDEX_W               = 1;
   localparam int CSR_DATA_W                = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADING_GAIN  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORWARD_SPEED = 1'd1;

   localparam logic [15:0] HEADING_GAIN_RESET  = 16'd15974;
   localparam logic [15:0] FORWARD_SPEED_RESET = 16'd256;
   localparam logic [15:0] ROBOT_POS_RESET     = 16'd1408;

   localparam logic signed [22:0] PI_UNITS = 23'sd3294199;
   localparam logic signed [19:0] ANG_MAX  = 20'sd524287;
   localparam logic signed [19:0] ANG_MIN  = -20'sd524288;

   localparam logic        REQ_POSE   = 1'b0;
   localparam logic        REQ_TARGET = 1'b1;

   // atan(2^-i) in units of 2^-20 rad
   localparam logic [ATAN_W-1:0] ATAN_TABLE [ANG_TABLE_LEN] = '{
      20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
      20'd16383,  20'd8192,   20'd4096,   20'd2048,   20'd1024,  20'd512,
      20'd256,    20'd128,    20'd64,     20'd32,     20'd16,    20'd8,
      20'd4,      20'd2,      20'd1,      20'd1,      20'd0,     20'd0
   };

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] heading_in;
   } req_payload_type;

   typedef struct packed {
      logic        [15:0] linear_cmd;
      logic signed [19:0] angular_cmd;
   } rsp_payload_type;

   typedef struct packed {
      logic                   load_pose;
      logic                   load_target;
      logic                   iter_en;
      logic [TABLE_IDX_W-1:0] iter_idx;
      logic                   angle_en;
      logic                   mult_en;
      logic                   out_load;
   } hps_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } hps_status_type;

endpackage

>>> rtl/hps_ctrl.sv
// Controller for the heading proportional steering block.
// Sequences load, CORDIC iterations, angle difference, multiply and output load.
// Depends on hps_pkg.
module hps_ctrl #(
   parameter int CORDIC_ITERATIONS = hps_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_accept,
   input  logic                    req_kind,
   input  hps_pkg::hps_status_type status,
   output logic                    req_stall,
   output hps_pkg::hps_cmd_type    cmd
);

   localparam int IterW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_ITERATIONS - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ITER  = 5'b00010,
      ST_ANGLE = 5'b00100,
      ST_MULT  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IterW-1:0] iter_ff, iter_in;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      case (state_ff)
         ST_IDLE: begin
            iter_in = '0;
            if (req_accept && (req_kind == hps_pkg::REQ_TARGET)) begin
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            iter_in = iter_ff + IterW'(1);
            if (iter_ff == IterLast) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: state_in = ST_MULT;
         ST_MULT:  state_in = ST_OUT;
         ST_OUT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd.load_pose   = req_accept && (req_kind == hps_pkg::REQ_POSE);
      cmd.load_target = req_accept && (req_kind == hps_pkg::REQ_TARGET);
      cmd.iter_en     = (state_ff == ST_ITER);
      cmd.iter_idx    = hps_pkg::TABLE_IDX_W'(iter_ff);
      cmd.angle_en    = (state_ff == ST_ANGLE);
      cmd.mult_en     = (state_ff == ST_MULT);
      cmd.out_load    = (state_ff == ST_OUT) && status.rsp_free;
   end

   a_iter_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) && (iter_ff == IterLast) |=> (state_ff == ST_ANGLE))
      else $error("CORDIC did not finish after the last iteration");

   a_mult_from_angle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT) |-> $past(state_ff == ST_ANGLE))
      else $error("multiply step not preceded by angle step");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && !status.rsp_free |=> (state_ff == ST_OUT))
      else $error("result dropped while output register busy");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.load_target && !cmd.load_pose)
      else $error("transaction taken while a target is in progress");

endmodule

>>> rtl/hps_dpath.sv
// Datapath for the heading proportional steering block.
// Pose and config registers, iterative vectoring CORDIC, gain multiply, output register.
// Depends on hps_pkg.
module hps_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  hps_pkg::req_payload_type            req_data,
   input  logic                                csr_we,
   input  logic [hps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                rsp_stall,
   input  hps_pkg::hps_cmd_type                cmd,
   output hps_pkg::hps_status_type             status,
   output logic                                rsp_valid,
   output hps_pkg::rsp_payload_type            rsp_data
);

   logic [15:0]        gain_ff, speed_ff;
   logic signed [15:0] robot_x_ff, robot_y_ff, robot_hd_ff;
   logic signed [31:0] x_ff, y_ff;
   logic signed [21:0] z_ff;
   logic signed [22:0] base_ff;
   logic               zero_ff;
   logic signed [17:0] diff_ff;
   logic signed [34:0] prod_ff;
   logic               rsp_valid_ff;
   hps_pkg::rsp_payload_type rsp_data_ff;

   logic signed [16:0] dx, dy;
   logic signed [31:0] x0, y0, xs, ys;
   logic signed [21:0] atan_step;
   logic signed [23:0] ang_sum;
   logic signed [15:0] ang_q12;
   logic signed [35:0] prod_rnd;
   logic signed [22:0] prod_q12;
   logic signed [19:0] ang_sat;

   assign dx = {req_data.pos_x[15], req_data.pos_x} - {robot_x_ff[15], robot_x_ff};
   assign dy = {req_data.pos_y[15], req_data.pos_y} - {robot_y_ff[15], robot_y_ff};
   assign x0 = {{3{dx[16]}}, dx, 12'b0};
   assign y0 = {{3{dy[16]}}, dy, 12'b0};

   assign xs        = x_ff >>> cmd.iter_idx;
   assign ys        = y_ff >>> cmd.iter_idx;
   assign atan_step = signed'({2'b00, hps_pkg::ATAN_TABLE[cmd.iter_idx]});

   assign ang_sum = {{2{z_ff[21]}}, z_ff} + {base_ff[22], base_ff} + 24'sd128;
   assign ang_q12 = zero_ff ? 16'sd0 : 16'(ang_sum >>> 8);

   assign prod_rnd = {prod_ff[34], prod_ff} + 36'sd2048;
   assign prod_q12 = 23'(prod_rnd >>> 12);

   always_comb begin
      if (prod_q12 > 23'(hps_pkg::ANG_MAX)) begin
         ang_sat = hps_pkg::ANG_MAX;
      end else if (prod_q12 < 23'(hps_pkg::ANG_MIN)) begin
         ang_sat = hps_pkg::ANG_MIN;
      end else begin
         ang_sat = 20'(prod_q12);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= hps_pkg::HEADING_GAIN_RESET;
         speed_ff    <= hps_pkg::FORWARD_SPEED_RESET;
         robot_x_ff  <= hps_pkg::ROBOT_POS_RESET;
         robot_y_ff  <= hps_pkg::ROBOT_POS_RESET;
         robot_hd_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               hps_pkg::CSR_HEADING_GAIN:  gain_ff  <= csr_wdata;
               hps_pkg::CSR_FORWARD_SPEED: speed_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load_pose) begin
            robot_x_ff  <= req_data.pos_x;
            robot_y_ff  <= req_data.pos_y;
            robot_hd_ff <= req_data.heading_in;
         end
      end
   end

   // CORDIC vectoring, angle difference, gain scaling and output payload, payload only
   always_ff @(posedge clock) begin
      if (cmd.load_target) begin
         zero_ff <= (dx == 17'sd0) && (dy == 17'sd0);
         z_ff    <= '0;
         if (dx[16]) begin
            x_ff    <= -x0;
            y_ff    <= -y0;
            base_ff <= dy[16] ? -hps_pkg::PI_UNITS : hps_pkg::PI_UNITS;
         end else begin
            x_ff    <= x0;
            y_ff    <= y0;
            base_ff <= '0;
         end
      end else if (cmd.iter_en) begin
         if (!y_ff[31]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_step;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_step;
         end
      end
      if (cmd.angle_en) begin
         diff_ff <= {{2{ang_q12[15]}}, ang_q12} - {{2{robot_hd_ff[15]}}, robot_hd_ff};
      end
      if (cmd.mult_en) begin
         prod_ff <= 35'(signed'({1'b0, gain_ff}) * diff_ff);
      end
      if (cmd.out_load) begin
         rsp_data_ff.linear_cmd  <= speed_ff;
         rsp_data_ff.angular_cmd <= ang_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

>>> rtl/heading_proportional_steering.sv
// Go-to-goal heading steering: pose updates are stored, a target yields one velocity command.
// Pose transaction: stored, no result. Target transaction: result registered after the
// CORDIC iterations, angle difference and gain multiply; no further transaction is taken
// until it is loaded into the output register, as the single-step CORDIC stage is shared.
// A finished result waits in the output register; the next transaction is taken meanwhile.
// Synchronous active-high reset: gain 3.9, speed 1.0, robot at (5.5, 5.5) heading 0.
module heading_proportional_steering #(
   parameter int CORDIC_ITERATIONS = hps_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  hps_pkg::req_payload_type        req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output hps_pkg::rsp_payload_type        rsp_data,
   input  logic                            csr_we,
   input  logic [hps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   hps_pkg::hps_cmd_type    cmd;
   hps_pkg::hps_status_type status;
   logic                    req_accept;

   assign req_accept = req_valid && !req_stall;

   hps_ctrl #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_kind   (req_data.req_type),
      .status     (status),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   hps_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
